// ----- design/exponential_delta_nibble_codec_defines.svh -----
// Assertion macros for the exponential delta nibble codec.
`ifndef EXPONENTIAL_DELTA_NIBBLE_CODEC_DEFINES_SVH
`define EXPONENTIAL_DELTA_NIBBLE_CODEC_DEFINES_SVH
`ifndef ASSERT_OFF
`define EDN_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("edn assertion failed");
`define EDN_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("edn assertion failed");
`else
`define EDN_ASSERT(label, clk, rst, prop)
`define EDN_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- design/edn_pkg.sv -----
// Code tables and helpers for the exponential delta nibble codec.
package edn_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] code_type;

   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned ErrLimit    = 128;

   function automatic code_type fit_code(input byte_type diff);
      code_type code;
      case (diff) inside
         8'd0:           code = 4'h0;
         8'd1:           code = 4'h1;
         [8'd2:8'd3]:    code = 4'h2;
         [8'd4:8'd6]:    code = 4'h3;
         [8'd7:8'd12]:   code = 4'h4;
         [8'd13:8'd24]:  code = 4'h5;
         [8'd25:8'd48]:  code = 4'h6;
         [8'd49:8'd96]:  code = 4'h7;
         [8'd97:8'd159]: code = 4'h8;
         [8'd160:8'd206]: code = 4'h9;
         [8'd207:8'd230]: code = 4'ha;
         [8'd231:8'd243]: code = 4'hb;
         [8'd244:8'd249]: code = 4'hc;
         [8'd250:8'd252]: code = 4'hd;
         [8'd253:8'd254]: code = 4'he;
         default:        code = 4'hf;
      endcase
      return code;
   endfunction

   function automatic byte_type delta_of(input code_type code);
      byte_type d;
      case (code)
         4'h0:    d = 8'h00;
         4'h1:    d = 8'h01;
         4'h2:    d = 8'h02;
         4'h3:    d = 8'h04;
         4'h4:    d = 8'h08;
         4'h5:    d = 8'h10;
         4'h6:    d = 8'h20;
         4'h7:    d = 8'h40;
         4'h8:    d = 8'h80;
         4'h9:    d = 8'hc0;
         4'ha:    d = 8'he0;
         4'hb:    d = 8'hf0;
         4'hc:    d = 8'hf8;
         4'hd:    d = 8'hfc;
         4'he:    d = 8'hfe;
         default: d = 8'hff;
      endcase
      return d;
   endfunction

endpackage

// ----- design/exponential_delta_nibble_codec.sv -----
// Exponential delta nibble codec: 8-bit PCM to packed 4-bit codes and back.
// Latency: results are registered, visible the cycle after the item is taken.
// Throughput: one item per cycle when encoding, while rsp_ready holds; when
// decoding, a new byte waits until the two-entry result queue has drained.
// Reset (synchronous): predictor, held nibble, mode and result queue clear.
`include "exponential_delta_nibble_codec_defines.svh"
module exponential_delta_nibble_codec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  edn_pkg::byte_type    req_data_byte,
   input  logic                 req_stream_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output edn_pkg::byte_type    rsp_out_byte,
   output logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);
   import edn_pkg::*;

   logic       mode_ff, mode_in;
   byte_type   pred_ff, pred_in;
   code_type   pend_ff, pend_in;
   logic       have_ff, have_in;

   byte_type   q_data_ff [2];
   logic       q_last_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   logic       req_fire, rsp_fire;
   logic [1:0] left_after_pop;
   logic [1:0] n_push;
   byte_type   push_data [2];
   logic       push_last [2];

   // encode path
   byte_type   enc_diff, enc_recon, enc_pred;
   code_type   enc_code0, enc_code;
   logic signed [8:0] enc_err;
   logic       enc_far;
   // decode path
   byte_type   dec_s0, dec_s1;

   assign csr_ready      = 1'b1;
   assign rsp_fire       = rsp_valid && rsp_ready;
   assign left_after_pop = count_ff - {1'b0, rsp_fire};
   assign req_ready      = (left_after_pop == 2'd0);
   assign req_fire       = req_valid && req_ready;
   assign rsp_valid      = (count_ff != 2'd0);
   assign rsp_out_byte   = q_data_ff[rd_ptr_ff];
   assign rsp_last_of_run = q_last_ff[rd_ptr_ff];

   always_comb begin
      enc_diff  = req_data_byte - pred_ff;
      enc_code0 = fit_code(enc_diff);
      enc_recon = pred_ff + delta_of(enc_code0);
      enc_err   = $signed({1'b0, req_data_byte}) - $signed({1'b0, enc_recon});
      enc_far   = (enc_err > $signed(9'(ErrLimit))) || (enc_err < -$signed(9'(ErrLimit)));
      enc_code  = enc_code0;
      if (enc_far) begin
         if (req_data_byte < pred_ff) begin
            enc_code = enc_code0 + 4'd1;
         end else begin
            enc_code = enc_code0 - 4'd1;
         end
      end
      enc_pred = pred_ff + delta_of(enc_code);
      dec_s0   = pred_ff + delta_of(req_data_byte[7:NibbleWidth]);
      dec_s1   = dec_s0 + delta_of(req_data_byte[NibbleWidth-1:0]);
   end

   always_comb begin
      mode_in      = mode_ff;
      pred_in      = pred_ff;
      pend_in      = pend_ff;
      have_in      = have_ff;
      n_push       = 2'd0;
      push_data[0] = req_data_byte;
      push_data[1] = dec_s1;
      push_last[0] = 1'b1;
      push_last[1] = 1'b1;
      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end
      if (req_fire) begin
         if (req_stream_start) begin
            pred_in = req_data_byte;
            pend_in = '0;
            have_in = 1'b0;
            n_push  = 2'd1;
         end else if (mode_ff) begin
            pred_in      = dec_s1;
            push_data[0] = dec_s0;
            push_last[0] = 1'b0;
            n_push       = 2'd2;
         end else if (!have_ff) begin
            pred_in = enc_pred;
            pend_in = enc_code;
            have_in = 1'b1;
         end else begin
            pred_in      = enc_pred;
            pend_in      = '0;
            have_in      = 1'b0;
            push_data[0] = {pend_ff, enc_code};
            n_push       = 2'd1;
         end
      end
      count_in  = left_after_pop + n_push;
      rd_ptr_in = rd_ptr_ff ^ rsp_fire;
      wr_ptr_in = wr_ptr_ff ^ n_push[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         pred_ff   <= '0;
         pend_ff   <= '0;
         have_ff   <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         mode_ff   <= mode_in;
         pred_ff   <= pred_in;
         pend_ff   <= pend_in;
         have_ff   <= have_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_data_ff[wr_ptr_ff] <= push_data[0];
         q_last_ff[wr_ptr_ff] <= push_last[0];
      end
      if (n_push == 2'd2) begin
         q_data_ff[~wr_ptr_ff] <= push_data[1];
         q_last_ff[~wr_ptr_ff] <= push_last[1];
      end
   end

   `EDN_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= 2'd2))
   `EDN_ASSERT(a_decode_fills, clock, reset, req_fire && !req_stream_start && mode_ff |=> count_ff == 2'd2)
   `EDN_ASSERT(a_half_held, clock, reset, req_fire && !req_stream_start && !mode_ff && !have_ff |=> have_ff)
   `EDN_ASSERT(a_ptr_gap, clock, reset, (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the exponential delta nibble codec.
module testbench;
   import edn_pkg::*;

   localparam logic ENCODE_MODE = 1'b0;
   localparam logic DECODE_MODE = 1'b1;

   typedef struct {
      byte_type value;
      logic     last;
   } codec_result_type;

   class codec_scoreboard;
      codec_result_type pending_results[$];
      logic          mode;
      byte_type      pred;
      code_type      held_code;
      logic          held_valid;
      int            errors;

      function new();
         mode       = ENCODE_MODE;
         pred       = '0;
         held_code  = '0;
         held_valid = 1'b0;
         errors     = 0;
      endfunction

      function byte_type step_of(input code_type c);
         if (c == 4'h0) return 8'h00;
         if (c <= 4'h8) return byte_type'(1 << (c - 1));
         return byte_type'(-(64 >> (c - 9)));
      endfunction

      function code_type code_for(input byte_type diff);
         if (diff == 8'd0) return 4'h0;
         if (diff == 8'd1) return 4'h1;
         if (diff <= 8'd3) return 4'h2;
         if (diff <= 8'd6) return 4'h3;
         if (diff <= 8'd12) return 4'h4;
         if (diff <= 8'd24) return 4'h5;
         if (diff <= 8'd48) return 4'h6;
         if (diff <= 8'd96) return 4'h7;
         if (diff <= 8'd159) return 4'h8;
         if (diff <= 8'd206) return 4'h9;
         if (diff <= 8'd230) return 4'ha;
         if (diff <= 8'd243) return 4'hb;
         if (diff <= 8'd249) return 4'hc;
         if (diff <= 8'd252) return 4'hd;
         if (diff <= 8'd254) return 4'he;
         return 4'hf;
      endfunction

      // code for one sample, predictor advances by the chosen delta
      function code_type encode_pcm(input byte_type pcm);
         code_type c;
         byte_type recon;
         int       err;
         c     = code_for(byte_type'(pcm - pred));
         recon = pred + step_of(c);
         err   = int'(pcm) - int'(recon);
         if (err > int'(ErrLimit) || err < -int'(ErrLimit)) begin
            if (pcm < pred) c = c + 4'h1;
            else c = c - 4'h1;
         end
         pred = pred + step_of(c);
         return c;
      endfunction

      function void queue_result(input byte_type value, input logic last);
         codec_result_type r;
         r.value = value;
         r.last  = last;
         pending_results.push_back(r);
      endfunction

      function void note_item(input byte_type data, input logic start);
         code_type low;
         if (start) begin
            pred       = data;
            held_valid = 1'b0;
            held_code  = '0;
            queue_result(data, 1'b1);
         end else if (mode == DECODE_MODE) begin
            pred = pred + step_of(data[7:4]);
            queue_result(pred, 1'b0);
            pred = pred + step_of(data[3:0]);
            queue_result(pred, 1'b1);
         end else if (!held_valid) begin
            held_code  = encode_pcm(data);
            held_valid = 1'b1;
         end else begin
            low = encode_pcm(data);
            queue_result({held_code, low}, 1'b1);
            held_valid = 1'b0;
            held_code  = '0;
         end
      endfunction

      task report(input string what, input int got, input int want);
         $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
         errors++;
      endtask

      task check_item(input byte_type value, input logic last);
         codec_result_type r;
         if (pending_results.size() == 0) begin
            report("unexpected item", int'(value), 0);
         end else begin
            r = pending_results.pop_front();
            if (value !== r.value) report("out_byte", int'(value), int'(r.value));
            if (last !== r.last) report("last_of_run", int'(last), int'(r.last));
         end
      endtask

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic     clock            = 1'b0;
   logic     reset            = 1'b1;
   logic     req_valid        = 1'b0;
   logic     req_ready;
   byte_type req_data_byte    = '0;
   logic     req_stream_start = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready        = 1'b0;
   byte_type rsp_out_byte;
   logic     rsp_last_of_run;
   logic     csr_valid        = 1'b0;
   logic     csr_ready;
   logic     csr_data         = 1'b0;

   codec_scoreboard board = new();
   int   results_seen  = 0;
   logic sender_quiet  = 1'b0;

   exponential_delta_nibble_codec i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input byte_type data, input logic start);
      int gap;
      gap = sender_quiet ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_stream_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(data, start);
   endtask

   // wait until every expected item is out, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input logic mode, input int count);
      int       sent;
      int       run;
      int       amp;
      byte_type pcm;
      write_mode(mode);
      sent = 0;
      while (sent < count) begin
         sender_quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 85) begin
            pcm = byte_type'($urandom);
            send_item(pcm, 1'b1);
            run = $urandom_range(1, 40);
            amp = 1 << $urandom_range(0, 7);
            repeat (run) begin
               if (mode == DECODE_MODE) pcm = byte_type'($urandom);
               else pcm = pcm + byte_type'($urandom_range(0, 2 * amp) - amp);
               send_item(pcm, 1'b0);
            end
            sent += run + 1;
         end else begin
            run = $urandom_range(1, 8);
            repeat (run) send_item(byte_type'($urandom), $urandom_range(0, 7) == 0);
            sent += run;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_item(rsp_out_byte, rsp_last_of_run);
         results_seen++;
      end
   end

   // receiver: random stalls, quiet stretches, one long hold-off
   initial begin
      int   hold_left;
      int   off_left;
      int   stretch_left;
      logic quiet;
      logic hold_done;
      hold_left    = 0;
      off_left     = 0;
      stretch_left = 0;
      quiet        = 1'b0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (stretch_left == 0) begin
            quiet        = ($urandom_range(0, 3) == 0);
            stretch_left = $urandom_range(16, 96);
         end
         stretch_left--;
         if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else if (off_left > 0) begin
            off_left--;
            rsp_ready <= 1'b0;
         end else begin
            off_left = pick_gap();
            if (off_left > 0) begin
               off_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      #12_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no stream start yet: coding runs from predictor zero
      write_mode(ENCODE_MODE);
      send_item(8'h00, 1'b0);
      send_item(8'hff, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7f, 1'b0);
      // code nudged down, then up
      send_item(8'd200, 1'b1);
      send_item(8'd250, 1'b0);
      send_item(8'd0, 1'b0);
      send_item(8'd50, 1'b1);
      send_item(8'd0, 1'b0);
      send_item(8'hff, 1'b0);
      // odd trailing sample dropped by a new stream
      send_item(8'h10, 1'b1);
      send_item(8'h20, 1'b0);
      send_item(8'h90, 1'b1);
      send_item(8'h91, 1'b0);
      send_item(8'h92, 1'b0);
      // held nibble kept across a mode change
      send_item(8'h40, 1'b0);
      write_mode(DECODE_MODE);
      send_item(8'h00, 1'b0);
      send_item(8'hff, 1'b0);
      send_item(8'h18, 1'b0);
      send_item(8'h9f, 1'b0);
      write_mode(ENCODE_MODE);
      send_item(8'h60, 1'b0);
      write_mode(DECODE_MODE);
      send_item(8'h55, 1'b1);
      send_item(8'h81, 1'b0);
      send_item(8'h7e, 1'b0);

      random_phase(ENCODE_MODE, 200);
      random_phase(DECODE_MODE, 200);
      random_phase(ENCODE_MODE, 200);
      random_phase(DECODE_MODE, 200);
      random_phase(DECODE_MODE, 200);
      random_phase(ENCODE_MODE, 200);
      random_phase(1'($urandom_range(0, 1)), 200);
      random_phase(1'($urandom_range(0, 1)), 200);

      drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
